// ===== design/u8dc_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decode and classify: shared package
// Widths, sequence length codes and the records passed between pipeline stages.
// ----------------------------------------------------------------------------
package u8dc_pkg;

    localparam int CP_W  = 21;
    localparam int LEN_W = 3;
    localparam int PAY_W = 6;

    localparam logic [LEN_W-1:0] LEN_ONE   = 3'd1;
    localparam logic [LEN_W-1:0] LEN_TWO   = 3'd2;
    localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
    localparam logic [LEN_W-1:0] LEN_FOUR  = 3'd4;

    // Input window, byte_zero first.
    typedef struct packed {
        logic [7:0] byte_three;
        logic [7:0] byte_two;
        logic [7:0] byte_one;
        logic [7:0] byte_zero;
    } window_t;

    // Result of the lead byte stage.
    typedef struct packed {
        logic [LEN_W-1:0] seq_len;
        logic             err;
        logic [6:0]       lead_pay;
        logic [PAY_W-1:0] pay1;
        logic [PAY_W-1:0] pay2;
        logic [PAY_W-1:0] pay3;
    } lead_t;

    // Result of the assembly stage.
    typedef struct packed {
        logic [CP_W-1:0]  cp;
        logic [LEN_W-1:0] seq_len;
        logic             err;
    } cp_t;

    // Final result record.
    typedef struct packed {
        logic [CP_W-1:0]  cp;
        logic [LEN_W-1:0] seq_len;
        logic             err;
        logic             blank;
        logic             punct;
    } result_t;

endpackage

// ===== design/u8dc_lead.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decode and classify: lead byte stage
// Decodes the sequence length from the lead byte and checks continuation bytes.
// ----------------------------------------------------------------------------
module u8dc_lead (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  u8dc_pkg::window_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output u8dc_pkg::lead_t   out_data
);

    logic            valid_reg;
    u8dc_pkg::lead_t data_reg;
    u8dc_pkg::lead_t data_next;

    logic [7:0] b0;
    logic       cont1_ok;
    logic       cont2_ok;
    logic       cont3_ok;

    assign b0       = in_data.byte_zero;
    assign cont1_ok = (in_data.byte_one[7:6] == 2'b10);
    assign cont2_ok = (in_data.byte_two[7:6] == 2'b10);
    assign cont3_ok = (in_data.byte_three[7:6] == 2'b10);

    always_comb begin
        data_next.pay1 = in_data.byte_one[5:0];
        data_next.pay2 = in_data.byte_two[5:0];
        data_next.pay3 = in_data.byte_three[5:0];
        if (b0[7] == 1'b0) begin
            data_next.seq_len  = u8dc_pkg::LEN_ONE;
            data_next.lead_pay = b0[6:0];
            data_next.err      = 1'b0;
        end else if (b0[7:5] == 3'b110) begin
            data_next.seq_len  = u8dc_pkg::LEN_TWO;
            data_next.lead_pay = {2'b00, b0[4:0]};
            data_next.err      = !cont1_ok;
        end else if (b0[7:4] == 4'b1110) begin
            data_next.seq_len  = u8dc_pkg::LEN_THREE;
            data_next.lead_pay = {3'b000, b0[3:0]};
            data_next.err      = !(cont1_ok && cont2_ok);
        end else if (b0[7:3] == 5'b11110) begin
            data_next.seq_len  = u8dc_pkg::LEN_FOUR;
            data_next.lead_pay = {4'b0000, b0[2:0]};
            data_next.err      = !(cont1_ok && cont2_ok && cont3_ok);
        end else begin
            data_next.seq_len  = u8dc_pkg::LEN_ONE;
            data_next.lead_pay = 7'd0;
            data_next.err      = 1'b1;
        end
    end

    // Nothing is taken in while reset is held.
    assign in_ready = aresetn && (!valid_reg || out_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== design/u8dc_assemble.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decode and classify: code point assembly stage
// Joins the payload bits of the sequence into a code point, zero on error.
// ----------------------------------------------------------------------------
module u8dc_assemble (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  u8dc_pkg::lead_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output u8dc_pkg::cp_t   out_data
);

    logic          valid_reg;
    u8dc_pkg::cp_t data_reg;
    u8dc_pkg::cp_t data_next;
    logic [u8dc_pkg::CP_W-1:0] cp_raw;

    always_comb begin
        unique case (in_data.seq_len)
            u8dc_pkg::LEN_TWO:
                cp_raw = {10'd0, in_data.lead_pay[4:0], in_data.pay1};
            u8dc_pkg::LEN_THREE:
                cp_raw = {5'd0, in_data.lead_pay[3:0], in_data.pay1, in_data.pay2};
            u8dc_pkg::LEN_FOUR:
                cp_raw = {in_data.lead_pay[2:0], in_data.pay1, in_data.pay2,
                          in_data.pay3};
            default:
                cp_raw = {14'd0, in_data.lead_pay};
        endcase
        data_next.cp      = in_data.err ? '0 : cp_raw;
        data_next.seq_len = in_data.seq_len;
        data_next.err     = in_data.err;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== design/u8dc_classify.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decode and classify: classification stage
// Flags the code point as blank or punctuation against fixed range lists.
// ----------------------------------------------------------------------------
module u8dc_classify (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  u8dc_pkg::cp_t     in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output u8dc_pkg::result_t out_data
);

    logic              valid_reg;
    u8dc_pkg::result_t data_reg;
    u8dc_pkg::result_t data_next;

    logic [u8dc_pkg::CP_W-1:0] c;
    logic blank_hit;
    logic punct_hit;

    assign c = in_data.cp;

    always_comb begin
        blank_hit = (c <= 21'h20) || (c == 21'h7F) || (c == 21'hA0) ||
                    (c == 21'h1680) || (c >= 21'h2000 && c <= 21'h200A) ||
                    (c == 21'h2028) || (c == 21'h2029) || (c == 21'h202F) ||
                    (c == 21'h205F) || (c == 21'h3000);
        // Note the ranges opening just above 0x3000, 0xFF01 and 0xFF1A.
        punct_hit = (c >= 21'h21 && c <= 21'h2F) ||
                    (c >= 21'h3A && c <= 21'h40) ||
                    (c >= 21'h5B && c <= 21'h60) ||
                    (c >= 21'h7B && c <= 21'h7E) ||
                    (c >= 21'h2010 && c <= 21'h2027) ||
                    (c >= 21'h2030 && c <= 21'h205E) ||
                    (c >= 21'h2E00 && c <= 21'h2E7F) ||
                    (c >  21'h3000 && c <= 21'h303F) ||
                    (c >= 21'hFE10 && c <= 21'hFE1F) ||
                    (c >= 21'hFE30 && c <= 21'hFE4F) ||
                    (c >= 21'hFE50 && c <= 21'hFE6F) ||
                    (c >  21'hFF01 && c <= 21'hFF0F) ||
                    (c >  21'hFF1A && c <= 21'hFF20) ||
                    (c >= 21'hFF3B && c <= 21'hFF40) ||
                    (c >= 21'hFF5B && c <= 21'hFF65);
        data_next.cp      = in_data.cp;
        data_next.seq_len = in_data.seq_len;
        data_next.err     = in_data.err;
        data_next.blank   = blank_hit && !in_data.err;
        data_next.punct   = punct_hit && !in_data.err;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== design/utf8_decode_and_classify.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decode and classify: top level
// Decodes one UTF-8 sequence per request and classes the resulting code point.
// ----------------------------------------------------------------------------
// Each input request carries a four-byte window that starts at a character;
// s_tdata holds byte_zero in its lowest byte up to byte_three in its highest.
// Each request produces exactly one result request on the m_ side, carrying
// the code point and sequence length in m_tdata and three flags in m_tuser.
// The caller advances its window by the reported sequence length.
// The work runs through three register stages: lead byte decode and
// continuation checks, code point assembly, then classification into the
// output register. A request is registered in the lead, assembly and output
// registers in turn before m_tvalid rises. One request can be accepted in
// every cycle, so the sustained rate is one window per clock while the
// receiver keeps up. When the receiver holds m_tready low, the stages fill
// up one by one and s_tready falls only once all three hold a request;
// nothing is dropped or repeated. A synchronous active-low reset empties
// the pipeline and holds s_tready low; no table or state needs clearing,
// so the block accepts requests as soon as reset is released.
// ----------------------------------------------------------------------------
module utf8_decode_and_classify (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // byte_zero, byte_one, byte_two, byte_three
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,  // code_point[20:0], seq_length[23:21]
    output logic [2:0]  m_tuser   // decode_error, is_blank, is_punct
);

    u8dc_pkg::window_t window;
    u8dc_pkg::lead_t   lead_data;
    u8dc_pkg::cp_t     cp_data;
    u8dc_pkg::result_t res_data;

    logic lead_valid;
    logic lead_ready;
    logic cp_valid;
    logic cp_ready;

    assign window = u8dc_pkg::window_t'(s_tdata);

    // Stage one: length from the lead byte, continuation byte checks.
    u8dc_lead u_lead (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (window),
        .out_valid (lead_valid),
        .out_ready (lead_ready),
        .out_data  (lead_data)
    );

    // Stage two: the payload bits are joined into the code point.
    u8dc_assemble u_assemble (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (lead_valid),
        .in_ready  (lead_ready),
        .in_data   (lead_data),
        .out_valid (cp_valid),
        .out_ready (cp_ready),
        .out_data  (cp_data)
    );

    // Stage three: range tests, whose register is the output register.
    u8dc_classify u_classify (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (cp_valid),
        .in_ready  (cp_ready),
        .in_data   (cp_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res_data)
    );

    assign m_tdata = {res_data.seq_len, res_data.cp};
    assign m_tuser = {res_data.punct, res_data.blank, res_data.err};

`ifndef SYNTHESIS
    // An error result never carries a code point.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[20:0] == 21'd0))
        else $error("error result with non-zero code point");

    // Class flags are cleared on error and never both set.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && (m_tuser[1] || m_tuser[2])) &&
                     !(m_tuser[1] && m_tuser[2]))
        else $error("inconsistent class flags");

    // Sequence length stays within one to four bytes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[23:21] != 3'd0) && (m_tdata[23:21] <= 3'd4))
        else $error("sequence length out of range");

    // A result held back by the receiver stays put until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=>
        (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed before it was taken");
`endif

endmodule

// ===== sim/utf8_decode_and_classify_checker.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decode and classify: result checker
// Watches both stream channels, predicts the decode of every accepted window
// and compares each result request against the oldest prediction.
// ----------------------------------------------------------------------------
module utf8_decode_and_classify_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // byte_zero, byte_one, byte_two, byte_three
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // code_point[20:0], seq_length[23:21]
    input  logic [2:0]  m_tuser,   // decode_error, is_blank, is_punct
    output int          mismatch_count,
    output int          outstanding
);

    u8dc_pkg::result_t due_decodes[$];

    function automatic logic blank_char(input logic [u8dc_pkg::CP_W-1:0] c);
        return c <= 'h20 || c == 'h7F || c == 'hA0 || c == 'h1680 ||
               (c >= 'h2000 && c <= 'h200A) || c == 'h2028 || c == 'h2029 ||
               c == 'h202F || c == 'h205F || c == 'h3000;
    endfunction

    // Note the ranges that open one above 0x3000, 0xFF01 and 0xFF1A.
    function automatic logic punct_char(input logic [u8dc_pkg::CP_W-1:0] c);
        return (c >= 'h21 && c <= 'h2F) || (c >= 'h3A && c <= 'h40) ||
               (c >= 'h5B && c <= 'h60) || (c >= 'h7B && c <= 'h7E) ||
               (c >= 'h2010 && c <= 'h2027) || (c >= 'h2030 && c <= 'h205E) ||
               (c >= 'h2E00 && c <= 'h2E7F) || (c > 'h3000 && c <= 'h303F) ||
               (c >= 'hFE10 && c <= 'hFE1F) || (c >= 'hFE30 && c <= 'hFE4F) ||
               (c >= 'hFE50 && c <= 'hFE6F) || (c > 'hFF01 && c <= 'hFF0F) ||
               (c > 'hFF1A && c <= 'hFF20) || (c >= 'hFF3B && c <= 'hFF40) ||
               (c >= 'hFF5B && c <= 'hFF65);
    endfunction

    function automatic u8dc_pkg::result_t decode_window(input u8dc_pkg::window_t w);
        logic [7:0]        b [4];
        u8dc_pkg::result_t r;
        int                k;
        b[0] = w.byte_zero;
        b[1] = w.byte_one;
        b[2] = w.byte_two;
        b[3] = w.byte_three;
        r = '0;
        if (!b[0][7]) begin
            r.cp      = {14'd0, b[0][6:0]};
            r.seq_len = u8dc_pkg::LEN_ONE;
        end else if (b[0][7:5] == 3'b110) begin
            r.cp      = {16'd0, b[0][4:0]};
            r.seq_len = u8dc_pkg::LEN_TWO;
        end else if (b[0][7:4] == 4'b1110) begin
            r.cp      = {17'd0, b[0][3:0]};
            r.seq_len = u8dc_pkg::LEN_THREE;
        end else if (b[0][7:3] == 5'b11110) begin
            r.cp      = {18'd0, b[0][2:0]};
            r.seq_len = u8dc_pkg::LEN_FOUR;
        end else begin
            r.seq_len = u8dc_pkg::LEN_ONE;
            r.err     = 1'b1;
        end
        if (!r.err) begin
            for (k = 1; k < r.seq_len; k++) begin
                if (b[k][7:6] != 2'b10) begin
                    r.err = 1'b1;
                    break;
                end
                r.cp = {r.cp[u8dc_pkg::CP_W-u8dc_pkg::PAY_W-1:0],
                        b[k][u8dc_pkg::PAY_W-1:0]};
            end
        end
        if (r.err) begin
            r.cp = '0;
        end
        r.blank = !r.err && blank_char(r.cp);
        r.punct = !r.err && punct_char(r.cp);
        return r;
    endfunction

    initial begin
        mismatch_count = 0;
        outstanding    = 0;
    end

    always @(posedge aclk) begin
        u8dc_pkg::result_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                due_decodes.push_back(decode_window(u8dc_pkg::window_t'(s_tdata)));
            end
            if (m_tvalid && m_tready) begin
                if (due_decodes.size() == 0) begin
                    $error("result request with no decode outstanding: tdata %h tuser %b",
                           m_tdata, m_tuser);
                    mismatch_count++;
                end else begin
                    want = due_decodes.pop_front();
                    if (m_tdata[20:0] !== want.cp) begin
                        $error("code_point: expected %h, got %h", want.cp,
                               m_tdata[20:0]);
                        mismatch_count++;
                    end
                    if (m_tdata[23:21] !== want.seq_len) begin
                        $error("seq_length: expected %0d, got %0d", want.seq_len,
                               m_tdata[23:21]);
                        mismatch_count++;
                    end
                    if (m_tuser[0] !== want.err) begin
                        $error("decode_error: expected %b, got %b", want.err, m_tuser[0]);
                        mismatch_count++;
                    end
                    if (m_tuser[1] !== want.blank) begin
                        $error("is_blank: expected %b, got %b", want.blank, m_tuser[1]);
                        mismatch_count++;
                    end
                    if (m_tuser[2] !== want.punct) begin
                        $error("is_punct: expected %b, got %b", want.punct, m_tuser[2]);
                        mismatch_count++;
                    end
                end
            end
            outstanding = due_decodes.size();
        end
    end

endmodule

// ===== sim/utf8_decode_and_classify_tb.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decode and classify: testbench top
// Drives character windows into the decoder, stalls the result side at random
// and reports the verdict from the checker's mismatch and outstanding counts.
// ----------------------------------------------------------------------------
module utf8_decode_and_classify_tb;

    // Far above the slowest correct run: about 1950 requests, each of which
    // may meet a few idle cycles on the sending side and a few stalls on the
    // receiving side, plus the three-stage pipeline latency.
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_WINDOWS = 1925;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // byte_zero, byte_one, byte_two, byte_three
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // code_point[20:0], seq_length[23:21]
    logic [2:0]  m_tuser;         // decode_error, is_blank, is_punct

    int mismatch_count;
    int outstanding;
    int cycle_count = 0;

    // Random idling on each side can be switched off for a stretch.
    bit tx_gaps_on  = 1'b1;
    bit rx_stall_on = 1'b1;

    // Code points that sit on the edges of the blank and punctuation lists.
    int class_edges [] = '{
        'h20, 'h21, 'h2F, 'h30, 'h39, 'h3A, 'h40, 'h41, 'h5A, 'h5B, 'h60, 'h61,
        'h7A, 'h7B, 'h7E, 'h7F, 'hA0, 'h1680, 'h2000, 'h200A, 'h2010, 'h2027,
        'h2028, 'h2029, 'h202F, 'h2030, 'h205E, 'h205F, 'h2E00, 'h2E7F,
        'h3000, 'h303F, 'hFE10, 'hFE1F, 'hFE30, 'hFE4F, 'hFE50, 'hFE6F,
        'hFF01, 'hFF0F, 'hFF1A, 'hFF20, 'hFF3B, 'hFF40, 'hFF5B, 'hFF65
    };

    always #5 aclk = ~aclk;

    // The clock counter doubles as the watchdog for a hung handshake.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // The receiver drops m_tready in roughly a quarter of all cycles while
    // stalling is enabled, and otherwise accepts every result request.
    always @(negedge aclk) begin
        m_tready <= !(rx_stall_on && ($urandom_range(99) < 26));
    end

    utf8_decode_and_classify u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    utf8_decode_and_classify_checker u_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    // Sends one window as a request. It is entered and left at a falling
    // edge. Idle cycles go in first, with s_tvalid low, so that a valid that
    // stays high from one request to the next is never lowered and raised
    // again within the same time step.
    task automatic push_window(input logic [31:0] win);
        while (tx_gaps_on && $urandom_range(99) < 26) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= win;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Holds the sender back until every result request has come out.
    task automatic drain_decodes();
        s_tvalid <= 1'b0;
        while (outstanding != 0) begin
            @(negedge aclk);
        end
    endtask

    // Builds a random window. Most windows hold a well-formed sequence with
    // a random payload or a code point on a class boundary; some carry a
    // broken continuation byte, and the rest are raw random bytes. Bytes
    // beyond the sequence are always random, as the decoder must ignore them.
    function automatic logic [31:0] random_window();
        logic [31:0] raw;
        logic [20:0] cp;
        int          pick;
        int          n;
        int          k;
        int          top;
        raw  = $urandom();
        pick = $urandom_range(99);
        if (pick >= 90) begin
            return raw;
        end
        if (pick < 60) begin
            n  = $urandom_range(1, 4);
            cp = 21'($urandom() >> (n == 1 ? 25 : n == 2 ? 21 : n == 3 ? 16 : 11));
        end else if (pick < 75) begin
            cp = 21'(class_edges[$urandom_range(class_edges.size() - 1)]
                     + $urandom_range(2) - 1);
            n  = cp < 'h80 ? 1 : cp < 'h800 ? 2 : cp < 'h10000 ? 3 : 4;
        end else begin
            n  = $urandom_range(2, 4);
            cp = 21'($urandom() >> (n == 2 ? 21 : n == 3 ? 16 : 11));
        end
        case (n)
            1: raw[7:0] = {1'b0, cp[6:0]};
            2: raw[7:0] = {3'b110, cp[10:6]};
            3: raw[7:0] = {4'b1110, cp[15:12]};
            default: raw[7:0] = {5'b11110, cp[20:18]};
        endcase
        for (k = 1; k < n; k++) begin
            raw[8*k +: 8] = {2'b10, cp[6*(n-1-k) +: 6]};
        end
        // Spoil one continuation byte: its top bits become 00, 01 or 11.
        if (pick >= 75) begin
            k   = $urandom_range(1, n - 1);
            top = $urandom_range(2);
            raw[8*k+6 +: 2] = (top == 2) ? 2'b11 : 2'(top);
        end
        return raw;
    endfunction

    initial begin
        int i;

        // Reset is held low and released at a falling edge.
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed windows, byte_zero in the lowest byte.
        push_window(32'h00000000);   // NUL decodes cleanly and is blank
        push_window(32'h00000020);   // space, last code point of the low blank run
        push_window(32'h00000021);   // first punctuation character
        push_window(32'h0000007F);   // DEL is blank
        push_window(32'h0000A0C2);   // no-break space, two bytes
        push_window(32'h0000BFC3);   // plain two-byte letter
        push_window(32'h00809AE1);   // Ogham space mark, three bytes
        push_window(32'h008A80E2);   // end of the general space run
        push_window(32'h009080E2);   // start of the general punctuation run
        push_window(32'h008080E3);   // ideographic space: blank but not punctuation
        push_window(32'h0081BCEF);   // full-width exclamation mark: left out
        push_window(32'h009ABCEF);   // full-width colon: left out as well
        push_window(32'h00A5BDEF);   // top of the last punctuation range
        push_window(32'hBFBF8FF4);   // highest Unicode code point, four bytes
        push_window(32'hBFBFBFF7);   // largest value that four bytes can carry
        push_window(32'h00000080);   // stray continuation byte as lead
        push_window(32'hFFFFFFFF);   // lead byte of all ones, every input bit set
        push_window(32'h000000F8);   // five-byte lead pattern is refused
        push_window(32'h000041C2);   // second byte is not a continuation
        push_window(32'h00C080E2);   // third byte is not a continuation
        push_window(32'hFF8090F0);   // fourth byte is not a continuation
        push_window(32'hFFFFFF41);   // bytes past a single-byte sequence ignored
        push_window(32'h808080F0);   // overlong form of NUL is accepted
        push_window(32'h0080A0ED);   // surrogate half is accepted

        // Let the pipeline run dry before the random part starts.
        drain_decodes();
        @(negedge aclk);

        for (i = 0; i < RANDOM_WINDOWS; i++) begin
            // A long stretch in the middle runs at full rate on both sides.
            if (i == 800) begin
                tx_gaps_on  = 1'b0;
                rx_stall_on = 1'b0;
            end
            if (i == 1200) begin
                drain_decodes();
                @(negedge aclk);
                tx_gaps_on  = 1'b1;
                rx_stall_on = 1'b1;
            end
            push_window(random_window());
        end

        // Wait for the last result request, then a few cycles more so that
        // any spurious result from the pipeline would still be seen.
        drain_decodes();
        repeat (8) @(negedge aclk);

        if (mismatch_count == 0 && outstanding == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/u8dc_pkg.sv
design/u8dc_lead.sv
design/u8dc_assemble.sv
design/u8dc_classify.sv
design/utf8_decode_and_classify.sv
sim/utf8_decode_and_classify_checker.sv
sim/utf8_decode_and_classify_tb.sv
